>>> rtl/fpd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the framed packet deframer.
package fpd_pkg;

  localparam int unsigned NAME_BYTES_DEF = 32;
  localparam int unsigned HDR_BYTES      = 16;
  localparam int unsigned TAIL_BYTES     = 4;
  localparam int unsigned BEAT_BYTES     = HDR_BYTES + TAIL_BYTES;
  localparam int unsigned NUM_REGS       = 8;
  localparam int unsigned REG_IDX_W      = 3;
  localparam int unsigned HUNT_FULL      = 4;

  typedef enum logic [REG_IDX_W-1:0] {
    RegHead   = 3'd0,
    RegTail   = 3'd1,
    RegLogin1 = 3'd2,
    RegLogin2 = 3'd3,
    RegLogin3 = 3'd4,
    RegBeat   = 3'd5,
    RegInfo1  = 3'd6,
    RegInfo2  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    KindLogin1 = 3'd0,
    KindLogin2 = 3'd1,
    KindLogin3 = 3'd2,
    KindBeat   = 3'd3,
    KindInfo1  = 3'd4,
    KindInfo2  = 3'd5
  } kind_e;

  // outcome of replaying the seven bytes after a dropped head byte
  typedef struct packed {
    logic        hdr;
    logic [2:0]  cnt;
    logic [31:0] len;
    logic [31:0] win;
  } resync_t;

endpackage

>>> rtl/fpd_intf.sv
`timescale 1ns / 1ps
// Handshake channel interfaces: input byte, result item and register write.
interface fpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface fpd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_kind;
  logic       is_payload;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic       tail_ok;
  modport source (output valid, output frame_kind, output is_payload, output payload_byte,
                  output payload_index, output tail_ok, input ready);
  modport sink   (input valid, input frame_kind, input is_payload, input payload_byte,
                  input payload_index, input tail_ok, output ready);
endinterface

interface fpd_cfg_if import fpd_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/fpd_resync.sv
`timescale 1ns / 1ps
// Re-hunt of the seven bytes after a dropped head byte on a negative length.
module fpd_resync import fpd_pkg::*; (
  input  logic [31:0] head_i,
  input  logic [31:0] len_i,
  output resync_t     res_o
);

  logic [31:0] win4, win5, win6;

  assign win4 = {len_i[7:0], head_i[31:8]};
  assign win5 = {len_i[15:0], head_i[31:16]};
  assign win6 = {len_i[23:0], head_i[31:24]};

  always_comb begin
    res_o.win = len_i;
    if (win4 == head_i) begin
      res_o.hdr = 1'b1;
      res_o.cnt = 3'd7;
      res_o.len = {len_i[31:8], 8'h00};
    end else if (win5 == head_i) begin
      res_o.hdr = 1'b1;
      res_o.cnt = 3'd6;
      res_o.len = {len_i[31:16], 16'h0000};
    end else if (win6 == head_i) begin
      res_o.hdr = 1'b1;
      res_o.cnt = 3'd5;
      res_o.len = {len_i[31:24], 24'h000000};
    end else if (len_i == head_i) begin
      res_o.hdr = 1'b1;
      res_o.cnt = 3'd4;
      res_o.len = '0;
    end else begin
      // window full of the length bytes, still hunting
      res_o.hdr = 1'b0;
      res_o.cnt = 3'd4;
      res_o.len = len_i;
    end
  end

endmodule

>>> rtl/framed_packet_deframer.sv
`timescale 1ns / 1ps
// Framed packet deframer top level: head hunt, header decode, credential stream.
// Each accepted byte is held in the input register; its result is then registered in the output register.
// Throughput: one byte per cycle while each result is taken at once; a result left
// waiting holds the input after at most one more byte.
// Reset: asynchronous, clears the register bank, state and valid flags and starts hunting for the head word.
module framed_packet_deframer import fpd_pkg::*; #(
  parameter int unsigned NameBytes = NAME_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpd_cfg_if.sink    cfg_i,
  fpd_in_if.sink     in_i,
  fpd_out_if.source  out_o
);

  localparam int unsigned CredBytes = 2 * NameBytes;
  localparam int unsigned CredFrame = HDR_BYTES + CredBytes + TAIL_BYTES;

  typedef enum logic [4:0] {
    PhHunt    = 5'b00001,
    PhHeader  = 5'b00010,
    PhPayload = 5'b00100,
    PhTail    = 5'b01000,
    PhSkip    = 5'b10000
  } phase_e;

  logic [31:0] cfg_q [NUM_REGS];

  phase_e      phase_q, phase_d;
  logic [31:0] win_q, win_d;
  logic [31:0] len_q, len_d;
  logic [31:0] cmd_q, cmd_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] tail_q, tail_d;
  kind_e       kind_q, kind_d;

  logic        byte_vld_q;
  logic [7:0]  byte_q;
  logic        advance;

  logic        out_vld_q;
  logic [2:0]  out_kind_q;
  logic        out_pay_q;
  logic [7:0]  out_byte_q;
  logic [5:0]  out_idx_q;
  logic        out_ok_q;

  logic        res_vld;
  logic        res_pay;
  logic [7:0]  res_byte;
  logic [5:0]  res_idx;
  logic        res_ok;

  logic [31:0] hunt_win, len_sh, cmd_sh, tail_sh;
  logic        big, beat;
  resync_t     rs;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (cfg_i.valid) begin
      cfg_q[cfg_i.index] <= cfg_i.data;
    end
  end

  // input register and output register handshakes
  assign advance    = byte_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !byte_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      byte_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) byte_q <= in_i.data_byte;
  end

  fpd_resync u_resync (
    .head_i (cfg_q[RegHead]),
    .len_i  ({byte_q, len_q[31:8]}),
    .res_o  (rs)
  );

  assign hunt_win = {byte_q, win_q[31:8]};
  assign len_sh   = {byte_q, len_q[31:8]};
  assign cmd_sh   = {byte_q, cmd_q[31:8]};
  assign tail_sh  = {byte_q, tail_q[31:8]};
  assign big      = len_q >= 32'(CredFrame);
  assign beat     = len_q >= 32'(BEAT_BYTES);

  always_comb begin
    phase_d  = phase_q;
    win_d    = win_q;
    len_d    = len_q;
    cmd_d    = cmd_q;
    cnt_d    = cnt_q;
    tail_d   = tail_q;
    kind_d   = kind_q;
    res_vld  = 1'b0;
    res_pay  = 1'b0;
    res_byte = '0;
    res_idx  = '0;
    res_ok   = 1'b0;
    unique case (phase_q)
      PhHunt: begin
        win_d = hunt_win;
        if (cnt_q < 32'(HUNT_FULL)) cnt_d = cnt_q + 32'd1;
        if (cnt_q >= 32'(HUNT_FULL - 1) && hunt_win == cfg_q[RegHead]) begin
          phase_d = PhHeader;
          cnt_d   = 32'(HUNT_FULL);
          len_d   = '0;
          cmd_d   = '0;
        end
      end
      PhHeader: begin
        cnt_d = cnt_q + 32'd1;
        if (cnt_q < 32'd8) len_d = len_sh;
        else if (cnt_q >= 32'd12) cmd_d = cmd_sh;
        if (cnt_q == 32'd7 && byte_q[7]) begin
          // negative length: drop the first head byte and hunt again
          phase_d = rs.hdr ? PhHeader : PhHunt;
          cnt_d   = {29'd0, rs.cnt};
          len_d   = rs.len;
          win_d   = rs.win;
          if (rs.hdr) cmd_d = '0;
        end else if (cnt_q == 32'(HDR_BYTES - 1)) begin
          phase_d = PhPayload;
          cnt_d   = '0;
          tail_d  = '0;
          if (big && cmd_sh == cfg_q[RegLogin1]) kind_d = KindLogin1;
          else if (big && cmd_sh == cfg_q[RegLogin2]) kind_d = KindLogin2;
          else if (big && cmd_sh == cfg_q[RegLogin3]) kind_d = KindLogin3;
          else if (beat && cmd_sh == cfg_q[RegBeat]) begin
            kind_d  = KindBeat;
            phase_d = PhTail;
          end
          else if (big && cmd_sh == cfg_q[RegInfo1]) kind_d = KindInfo1;
          else if (big && cmd_sh == cfg_q[RegInfo2]) kind_d = KindInfo2;
          else begin
            phase_d = PhSkip;
            cnt_d   = len_q + 32'(TAIL_BYTES);
            tail_d  = tail_q;
          end
        end
      end
      PhPayload: begin
        res_vld  = 1'b1;
        res_pay  = 1'b1;
        res_idx  = cnt_q[5:0];
        res_byte = (cnt_q == 32'(NameBytes - 1) || cnt_q == 32'(CredBytes - 1))
                   ? 8'h00 : byte_q;
        cnt_d    = cnt_q + 32'd1;
        if (cnt_q == 32'(CredBytes - 1)) begin
          phase_d = PhTail;
          cnt_d   = '0;
          tail_d  = '0;
        end
      end
      PhTail: begin
        tail_d = tail_sh;
        cnt_d  = cnt_q + 32'd1;
        if (cnt_q == 32'(TAIL_BYTES - 1)) begin
          res_vld = 1'b1;
          res_ok  = tail_sh == cfg_q[RegTail];
          phase_d = PhHunt;
          win_d   = '0;
          cnt_d   = '0;
        end
      end
      PhSkip: begin
        if (cnt_q <= 32'd1) begin
          phase_d = PhHunt;
          win_d   = '0;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q - 32'd1;
        end
      end
      default: begin
        phase_d = PhHunt;
        win_d   = {byte_q, 24'h000000};
        cnt_d   = 32'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      win_q   <= '0;
      len_q   <= '0;
      cmd_q   <= '0;
      cnt_q   <= '0;
      tail_q  <= '0;
      kind_q  <= KindLogin1;
    end else if (advance) begin
      phase_q <= phase_d;
      win_q   <= win_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      cnt_q   <= cnt_d;
      tail_q  <= tail_d;
      kind_q  <= kind_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_vld;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_kind_q <= kind_q;
      out_pay_q  <= res_pay;
      out_byte_q <= res_byte;
      out_idx_q  <= res_idx;
      out_ok_q   <= res_ok;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.frame_kind    = out_kind_q;
  assign out_o.is_payload    = out_pay_q;
  assign out_o.payload_byte  = out_byte_q;
  assign out_o.payload_index = out_idx_q;
  assign out_o.tail_ok       = out_ok_q;

endmodule

>>> test/fpd_deframe_chk.sv
`timescale 1ns / 1ps
// Deframer checker: watches the channels, predicts each result item and compares.
module fpd_deframe_chk import fpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fpd_cfg_if          cfg_mon,
  fpd_in_if           in_mon,
  fpd_out_if          out_mon,
  output int unsigned pending_o,
  output int unsigned fails_o
);

  localparam int unsigned CredBytes = 2 * NAME_BYTES_DEF;
  localparam int unsigned CredFrame = HDR_BYTES + CredBytes + TAIL_BYTES;
  localparam int unsigned LenDone   = 8;
  localparam int unsigned CmdStart  = 12;

  typedef enum logic [2:0] {
    StHunt,
    StHeader,
    StCred,
    StTail,
    StSkip
  } deframe_st_e;

  typedef struct packed {
    logic [2:0] kind;
    logic       is_payload;
    logic [7:0] pbyte;
    logic [5:0] pidx;
    logic       tail_ok;
  } deframe_res_t;

  logic [31:0]  regs_q [NUM_REGS];
  logic [31:0]  win_q;
  logic [31:0]  len_q;
  logic [31:0]  cmd_q;
  logic [31:0]  cnt_q;
  logic [31:0]  tailw_q;
  deframe_st_e  st_q;
  kind_e        kind_q;
  deframe_res_t due_q [$];
  int unsigned  errs;

  function automatic void restart_hunt();
    st_q  = StHunt;
    win_q = '0;
    cnt_q = '0;
  endfunction

  function automatic void hunt_byte(input logic [7:0] b);
    win_q = {b, win_q[31:8]};
    if (cnt_q < HUNT_FULL) cnt_q++;
    if (cnt_q >= HUNT_FULL && win_q == regs_q[RegHead]) begin
      st_q  = StHeader;
      cnt_q = HUNT_FULL;
      len_q = '0;
      cmd_q = '0;
    end
  endfunction

  function automatic void header_byte(input logic [7:0] b);
    if (cnt_q < LenDone) begin
      len_q = {b, len_q[31:8]};
    end else if (cnt_q >= CmdStart && cnt_q < HDR_BYTES) begin
      cmd_q = {b, cmd_q[31:8]};
    end
    cnt_q++;
  endfunction

  // drop the first head byte, re-hunt the three head bytes and the length bytes after it
  function automatic void resync();
    logic [55:0] replay;
    replay = {len_q, regs_q[RegHead][31:8]};
    restart_hunt();
    for (int i = 0; i < 7; i++) begin
      if (st_q == StHeader) header_byte(replay[8*i +: 8]);
      else hunt_byte(replay[8*i +: 8]);
    end
  endfunction

  function automatic void classify();
    logic big;
    big = (len_q >= CredFrame);
    if (big && cmd_q == regs_q[RegLogin1]) begin
      kind_q = KindLogin1;
      st_q   = StCred;
    end else if (big && cmd_q == regs_q[RegLogin2]) begin
      kind_q = KindLogin2;
      st_q   = StCred;
    end else if (big && cmd_q == regs_q[RegLogin3]) begin
      kind_q = KindLogin3;
      st_q   = StCred;
    end else if (len_q >= BEAT_BYTES && cmd_q == regs_q[RegBeat]) begin
      kind_q = KindBeat;
      st_q   = StTail;
    end else if (big && cmd_q == regs_q[RegInfo1]) begin
      kind_q = KindInfo1;
      st_q   = StCred;
    end else if (big && cmd_q == regs_q[RegInfo2]) begin
      kind_q = KindInfo2;
      st_q   = StCred;
    end else begin
      st_q  = StSkip;
      cnt_q = len_q + TAIL_BYTES;
      return;
    end
    cnt_q   = '0;
    tailw_q = '0;
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    logic [7:0] v;
    case (st_q)
      StHeader: begin
        header_byte(b);
        if (cnt_q == LenDone && len_q[31]) resync();
        else if (cnt_q >= HDR_BYTES) classify();
      end
      StCred: begin
        v = b;
        if (cnt_q == NAME_BYTES_DEF - 1 || cnt_q == CredBytes - 1) v = '0;
        due_q.push_back('{kind: kind_q, is_payload: 1'b1, pbyte: v, pidx: cnt_q[5:0],
                          tail_ok: 1'b0});
        cnt_q++;
        if (cnt_q >= CredBytes) begin
          st_q    = StTail;
          cnt_q   = '0;
          tailw_q = '0;
        end
      end
      StTail: begin
        tailw_q = {b, tailw_q[31:8]};
        cnt_q++;
        if (cnt_q >= TAIL_BYTES) begin
          due_q.push_back('{kind: kind_q, is_payload: 1'b0, pbyte: 8'h00, pidx: 6'd0,
                            tail_ok: (tailw_q == regs_q[RegTail])});
          restart_hunt();
        end
      end
      StSkip: begin
        if (cnt_q > 0) cnt_q--;
        if (cnt_q == 0) restart_hunt();
      end
      default: hunt_byte(b);
    endcase
  endfunction

  function automatic void check_result();
    deframe_res_t got;
    deframe_res_t want;
    got = {out_mon.frame_kind, out_mon.is_payload, out_mon.payload_byte,
           out_mon.payload_index, out_mon.tail_ok};
    if (due_q.size() == 0) begin
      errs++;
      $display("%0t: unexpected item: expected none, actual kind=%0d payload=%0b byte=%02h",
               $time, got.kind, got.is_payload, got.pbyte,
               " index=%0d tail_ok=%0b", got.pidx, got.tail_ok);
      return;
    end
    want = due_q.pop_front();
    if (got !== want) begin
      errs++;
      $display("%0t: item mismatch: expected kind=%0d payload=%0b byte=%02h index=%0d",
               $time, want.kind, want.is_payload, want.pbyte, want.pidx,
               " tail_ok=%0b, actual kind=%0d payload=%0b byte=%02h index=%0d tail_ok=%0b",
               want.tail_ok, got.kind, got.is_payload, got.pbyte, got.pidx, got.tail_ok);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] = '0;
      win_q     = '0;
      len_q     = '0;
      cmd_q     = '0;
      cnt_q     = '0;
      tailw_q   = '0;
      st_q      = StHunt;
      kind_q    = KindLogin1;
      errs      = 0;
      due_q.delete();
      pending_o <= 0;
      fails_o   <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) regs_q[cfg_mon.index] = cfg_mon.data;
      if (in_mon.valid && in_mon.ready) take_byte(in_mon.data_byte);
      if (out_mon.valid && out_mon.ready) check_result();
      pending_o <= due_q.size();
      fails_o   <= errs;
    end
  end

endmodule

>>> test/tb_framed_packet_deframer.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, register loads, byte stream stimulus and verdict.
module tb_framed_packet_deframer import fpd_pkg::*;;

  localparam int unsigned CredBytes = 2 * NAME_BYTES_DEF;
  localparam int unsigned CredFrame = HDR_BYTES + CredBytes + TAIL_BYTES;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned pending;
  int unsigned fails;
  logic [31:0] cfg_val [NUM_REGS] = '{default: '0};
  int unsigned sent = 0;
  int unsigned goal;
  bit          calm = 1'b0;

  fpd_cfg_if cfg_ch ();
  fpd_in_if  in_ch ();
  fpd_out_if out_ch ();

  framed_packet_deframer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  fpd_deframe_chk u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_mon   (cfg_ch),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .pending_o (pending),
    .fails_o   (fails)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_framed_packet_deframer failed");
    $finish;
  end

  initial begin : sink_ready
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic load_regs();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_idx_e'(i);
      cfg_ch.data  <= cfg_val[i];
      @(posedge clk_i);
      while (!cfg_ch.ready) @(posedge clk_i);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8]);
  endtask

  // hunted bytes never share a value with the head word, so no false head shows up
  function automatic logic [7:0] free_byte(input logic top_bit);
    logic [7:0]  b;
    logic [31:0] h;
    h = cfg_val[RegHead];
    do begin
      b = 8'($urandom);
      if (top_bit) b[7] = 1'b1;
    end while (b == h[7:0] || b == h[15:8] || b == h[23:16] || b == h[31:24]);
    return b;
  endfunction

  function automatic logic [31:0] neg_len();
    return {free_byte(1'b1), free_byte(1'b0), free_byte(1'b0), free_byte(1'b0)};
  endfunction

  task automatic put_noise(input int unsigned n);
    repeat (n) put_byte(free_byte(1'b0));
  endtask

  // bytes that follow the header, by command priority and length
  function automatic int unsigned body_bytes(input logic [31:0] cmd, input logic [31:0] len);
    logic big;
    big = (len >= CredFrame);
    if (big && (cmd == cfg_val[RegLogin1] || cmd == cfg_val[RegLogin2] ||
                cmd == cfg_val[RegLogin3])) return CredBytes + TAIL_BYTES;
    if (len >= BEAT_BYTES && cmd == cfg_val[RegBeat]) return TAIL_BYTES;
    if (big && (cmd == cfg_val[RegInfo1] || cmd == cfg_val[RegInfo2]))
      return CredBytes + TAIL_BYTES;
    return len + TAIL_BYTES;
  endfunction

  task automatic send_frame(input logic [31:0] cmd, input logic [31:0] len, input bit good);
    int unsigned body;
    body = body_bytes(cmd, len);
    put_word(cfg_val[RegHead]);
    put_word(len);
    put_word($urandom);
    put_word(cmd);
    repeat (body - TAIL_BYTES) put_byte(8'($urandom));
    put_word(good ? cfg_val[RegTail] : cfg_val[RegTail] ^ (32'd1 << $urandom_range(0, 31)));
  endtask

  task automatic send_broken(input logic [31:0] len);
    put_word(cfg_val[RegHead]);
    put_word(len);
    put_noise($urandom_range(0, 6));
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned k;
    logic [31:0] cmd;
    logic [31:0] len;
    pick = $urandom_range(0, 19);
    k    = $urandom_range(0, 5);
    cmd  = cfg_val[int'(RegLogin1) + k];
    if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 3));
    if (pick < 14) begin
      len = ((k == 3) ? BEAT_BYTES : CredFrame) + $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(CredFrame, 32'h7FFF_FFFF);
      send_frame(cmd, len, $urandom_range(0, 3) != 0);
    end else if (pick < 16) begin
      send_frame(cmd, $urandom_range(0, CredFrame - 1), 1'b1);
    end else if (pick < 18) begin
      send_frame($urandom, $urandom_range(0, 40), 1'b1);
    end else begin
      send_broken(neg_len());
    end
  endtask

  task automatic random_run(input int unsigned n);
    goal = sent + n;
    while (sent < goal) random_frame();
  endtask

  // hold the stream until every result is out and the pipeline is empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= RegHead;
    cfg_ch.data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset: head of zeros must not match before four bytes are in
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h5A);
    send_frame(32'h0, CredFrame, 1'b1);
    send_frame(32'h0, BEAT_BYTES, 1'b0);
    settle();

    cfg_val[RegHead]   = 32'h1234_ABCD;
    cfg_val[RegTail]   = 32'h5EC0_7A11;
    cfg_val[RegLogin1] = 32'h0000_1001;
    cfg_val[RegLogin2] = 32'h0000_1002;
    cfg_val[RegLogin3] = 32'h0000_1003;
    cfg_val[RegBeat]   = 32'h0000_2000;
    cfg_val[RegInfo1]  = 32'h0000_3001;
    cfg_val[RegInfo2]  = 32'h0000_3002;
    load_regs();
    put_noise(4);
    send_frame(cfg_val[RegLogin1], CredFrame, 1'b1);
    send_frame(cfg_val[RegLogin2], 32'h7FFF_FFFF, 1'b0);
    send_frame(cfg_val[RegLogin3], CredFrame + 1, 1'b1);
    put_noise(2);
    send_frame(cfg_val[RegBeat], BEAT_BYTES, 1'b1);
    send_frame(cfg_val[RegBeat], BEAT_BYTES - 1, 1'b1);
    send_frame(cfg_val[RegInfo1], CredFrame, 1'b1);
    send_frame(cfg_val[RegInfo2], CredFrame, 1'b0);
    send_frame(cfg_val[RegLogin2], CredFrame - 1, 1'b1);
    send_frame(32'hDEAD_0000, 32'h0, 1'b1);
    put_noise(3);
    send_frame(cfg_val[RegBeat], 32'd100, 1'b1);
    send_broken(32'h8000_0000);
    send_broken(32'hFFFF_FFFF);
    random_run(30);
    settle();
    random_run(30);
    settle();

    cfg_val[RegHead]   = 32'hFFFF_FFFF;
    cfg_val[RegTail]   = 32'h0000_0000;
    cfg_val[RegLogin1] = 32'hFFFF_FFFF;
    cfg_val[RegLogin2] = 32'h0000_0000;
    cfg_val[RegLogin3] = 32'h8000_0000;
    cfg_val[RegBeat]   = 32'h7FFF_FFFF;
    cfg_val[RegInfo1]  = 32'h0000_0001;
    cfg_val[RegInfo2]  = 32'hFFFF_FFFE;
    load_regs();
    put_noise(4);
    send_broken(neg_len());
    random_run(30);
    settle();

    // shared codes: priority order decides the kind
    cfg_val[RegHead]   = 32'hA5A5_A5A5;
    cfg_val[RegTail]   = 32'hFFFF_FFFF;
    cfg_val[RegLogin1] = 32'h0000_0C0C;
    cfg_val[RegBeat]   = 32'h0000_0C0C;
    cfg_val[RegLogin2] = 32'h0D0D_0000;
    cfg_val[RegLogin3] = 32'h0D0D_0000;
    cfg_val[RegInfo1]  = 32'hE0E0_E0E0;
    cfg_val[RegInfo2]  = 32'hE0E0_E0E0;
    load_regs();
    put_noise(4);
    // negative length whose low byte re-forms the head on replay
    put_word(32'hA5A5_A5A5);
    put_word(32'h8000_00A5);
    put_byte(8'h80);
    put_noise(3);
    send_frame(cfg_val[RegLogin1], 32'd50, 1'b1);
    send_frame(cfg_val[RegLogin1], CredFrame, 1'b1);
    send_frame(cfg_val[RegLogin3], CredFrame, 1'b1);
    send_frame(cfg_val[RegInfo2], CredFrame, 1'b0);
    random_run(30);
    settle();

    calm = 1'b1;
    cfg_val[RegHead] = 32'h0000_0000;
    for (int i = int'(RegTail); i < NUM_REGS; i++) cfg_val[i] = $urandom;
    load_regs();
    put_noise(4);
    random_run(30);
    settle();

    if (fails == 0 && pending == 0) begin
      $display("tb_framed_packet_deframer passed");
    end else begin
      $display("tb_framed_packet_deframer failed");
    end
    $finish;
  end

endmodule
